[design/bpb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpb_pkg
// Types, register codes and constants of the Blinn-Phong BRDF evaluator.
// ----------------------------------------------------------------------------
package bpb_pkg;

    localparam int DIR_W     = 16;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LOG_FRAC  = 20;
    localparam int ALPHA_W   = 17;
    localparam int POW_W     = 31;

    localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;

    localparam logic [CFG_IDX_W-1:0] REG_DIFF_R = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_G = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEC_R = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEC_G = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEC_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIN   = 3'd6;

    typedef struct packed {
        logic signed [DIR_W-1:0] out_dir_x;
        logic signed [DIR_W-1:0] out_dir_y;
        logic signed [DIR_W-1:0] out_dir_z;
        logic signed [DIR_W-1:0] in_dir_x;
        logic signed [DIR_W-1:0] in_dir_y;
        logic signed [DIR_W-1:0] in_dir_z;
        logic signed [DIR_W-1:0] normal_x;
        logic signed [DIR_W-1:0] normal_y;
        logic signed [DIR_W-1:0] normal_z;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] value_red;
        logic [OUT_W-1:0] value_green;
        logic [OUT_W-1:0] value_blue;
        logic             clipped;
    } t_out_item;

    // elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [64:0] test;
        rem  = v;
        root = '0;
        for (int k = 31; k >= 0; k--) begin
            test = (65'(root) << (k + 1)) + (65'd1 << (2 * k));
            if ({1'b0, rem} >= test) begin
                rem  = rem - test[63:0];
                root = root | (64'd1 << k);
            end
        end
        return root;
    endfunction

    // 2^(-2^-(k+1)) in Q0.30, chained floor square roots
    function automatic logic [POW_W-1:0] root_q30(input int k);
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int i = 1; i < LOG_FRAC; i++) begin
            if (i <= k) begin
                r = isqrt64(r << 30);
            end
        end
        return r[POW_W-1:0];
    endfunction

    function automatic logic [3:0] lead_one(input logic [15:0] a);
        logic [3:0] e;
        e = '0;
        for (int i = 0; i < 16; i++) begin
            if (a[i]) begin
                e = 4'(i);
            end
        end
        return e;
    endfunction

endpackage

[design/bpb_alpha.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpb_alpha
// Half-vector cosine |dot(normalize(wo+wi), n)| in Q1.16, pipelined
// square root and division, one bit per stage.
// ----------------------------------------------------------------------------
module bpb_alpha import bpb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_in_item           i_item,
    output logic               o_valid,
    output logic [ALPHA_W-1:0] o_alpha
);

    localparam int SW      = DIR_W + 1;
    localparam int PW      = 2 * DIR_W + 2;
    localparam int DOT_W   = 2 * DIR_W + 4;
    localparam int LEN2_W  = 2 * DIR_W + 3;
    localparam int ADOT_W  = 2 * DIR_W + 2;
    localparam int RAD_SHL = 60 - 2 * DIR_W;
    localparam int RAD_W   = 62;
    localparam int ROOT_W  = 31;
    localparam int NUM_SHL = 48 - 2 * DIR_W;
    localparam int NUM_W   = 50;
    localparam int SQ_N    = ROOT_W;
    localparam int DV_N    = ALPHA_W;
    localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);

    logic signed [DIR_W-1:0] w_o [3];
    logic signed [DIR_W-1:0] w_i [3];
    logic signed [DIR_W-1:0] w_n [3];

    assign w_o[0] = i_item.out_dir_x;
    assign w_o[1] = i_item.out_dir_y;
    assign w_o[2] = i_item.out_dir_z;
    assign w_i[0] = i_item.in_dir_x;
    assign w_i[1] = i_item.in_dir_y;
    assign w_i[2] = i_item.in_dir_z;
    assign w_n[0] = i_item.normal_x;
    assign w_n[1] = i_item.normal_y;
    assign w_n[2] = i_item.normal_z;

    // stage A: sums, stage B: products, stage C: dot and |s|^2
    logic                    r_va, r_vb, r_vc;
    logic signed [SW-1:0]    r_s  [3];
    logic signed [DIR_W-1:0] r_n  [3];
    logic signed [PW-1:0]    r_pd [3];
    logic        [LEN2_W-1:0] r_sq [3];
    logic signed [DOT_W-1:0] r_dot;
    logic        [LEN2_W-1:0] r_len2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    logic signed [PW-1:0] w_ss [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ss[i] = PW'(r_s[i]) * PW'(r_s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i]  <= SW'(w_o[i]) + SW'(w_i[i]);
                r_n[i]  <= w_n[i];
                r_pd[i] <= PW'(r_s[i]) * PW'(r_n[i]);
                r_sq[i] <= LEN2_W'($unsigned(w_ss[i]));
            end
            r_dot  <= DOT_W'(r_pd[0]) + DOT_W'(r_pd[1]) + DOT_W'(r_pd[2]);
            r_len2 <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // stage D and square root stages
    logic                v_sq   [SQ_N+1];
    logic [RAD_W-1:0]    r_rem  [SQ_N+1];
    logic [ROOT_W-1:0]   r_root [SQ_N+1];
    logic [ADOT_W-1:0]   r_ad   [SQ_N+1];
    logic                r_nz   [SQ_N+1];

    logic [DOT_W-1:0] w_abs;
    assign w_abs = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v_sq[0] <= 1'b0;
        end else if (i_en) begin
            v_sq[0] <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RAD_W'(r_len2) << RAD_SHL;
            r_root[0] <= '0;
            r_ad[0]   <= w_abs[ADOT_W-1:0];
            r_nz[0]   <= (r_len2 != '0);
        end
    end

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam int K = SQ_N - 1 - j;
        logic [RAD_W:0] w_test;
        logic           w_take;

        assign w_test = ((RAD_W + 1)'(r_root[j]) << (K + 1)) + ((RAD_W + 1)'(1) << (2 * K));
        assign w_take = ({1'b0, r_rem[j]} >= w_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                v_sq[j+1] <= 1'b0;
            end else if (i_en) begin
                v_sq[j+1] <= v_sq[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_take ? r_rem[j] - w_test[RAD_W-1:0] : r_rem[j];
                r_root[j+1] <= w_take ? (r_root[j] | (ROOT_W'(1) << K)) : r_root[j];
                r_ad[j+1]   <= r_ad[j];
                r_nz[j+1]   <= r_nz[j];
            end
        end
    end

    // stage E and division stages
    logic                v_dv   [DV_N+1];
    logic [NUM_W-1:0]    r_drem [DV_N+1];
    logic [ROOT_W-1:0]   r_len  [DV_N+1];
    logic [ALPHA_W-1:0]  r_q    [DV_N+1];
    logic                r_ov   [DV_N+1];
    logic                r_dnz  [DV_N+1];

    logic [NUM_W-1:0] w_num;
    assign w_num = NUM_W'(r_ad[SQ_N]) << NUM_SHL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v_dv[0] <= 1'b0;
        end else if (i_en) begin
            v_dv[0] <= v_sq[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drem[0] <= w_num;
            r_len[0]  <= r_root[SQ_N];
            r_q[0]    <= '0;
            r_ov[0]   <= (w_num >= (NUM_W'(r_root[SQ_N]) << DV_N));
            r_dnz[0]  <= r_nz[SQ_N];
        end
    end

    for (genvar j = 0; j < DV_N; j++) begin : g_div
        localparam int K = DV_N - 1 - j;
        logic [NUM_W-1:0] w_test;
        logic             w_take;

        assign w_test = NUM_W'(r_len[j]) << K;
        assign w_take = (r_drem[j] >= w_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                v_dv[j+1] <= 1'b0;
            end else if (i_en) begin
                v_dv[j+1] <= v_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[j+1] <= w_take ? r_drem[j] - w_test : r_drem[j];
                r_q[j+1]    <= w_take ? (r_q[j] | (ALPHA_W'(1) << K)) : r_q[j];
                r_len[j+1]  <= r_len[j];
                r_ov[j+1]   <= r_ov[j];
                r_dnz[j+1]  <= r_dnz[j];
            end
        end
    end

    logic               r_valid;
    logic [ALPHA_W-1:0] r_alpha;
    logic [ALPHA_W-1:0] n_alpha;

    always_comb begin
        priority if (!r_dnz[DV_N]) begin
            n_alpha = '0;
        end else if (r_ov[DV_N] || (r_q[DV_N] > ONE_Q16)) begin
            n_alpha = ONE_Q16;
        end else begin
            n_alpha = r_q[DV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= v_dv[DV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha <= n_alpha;
        end
    end

    assign o_valid = r_valid;
    assign o_alpha = r_alpha;

endmodule

[design/bpb_pow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpb_pow
// alpha^shininess in Q1.30: log2 by repeated squaring, scale by the
// exponent, then 2^-x from a product of fixed roots and a shift.
// ----------------------------------------------------------------------------
module bpb_pow import bpb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [CFG_W-1:0]   i_shin,
    output logic               o_valid,
    output logic [POW_W-1:0]   o_pow
);

    localparam int LG_W   = LOG_FRAC + 5;
    localparam int PR_W   = LG_W + CFG_W;
    localparam int P_W    = PR_W - 6;
    localparam int IP_W   = P_W - LOG_FRAC;
    localparam logic [POW_W-1:0] ONE_Q30 = POW_W'(1) << 30;

    // log stages
    logic                v_lg [LOG_FRAC+1];
    logic [POW_W-1:0]    r_x  [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] r_fr [LOG_FRAC+1];
    logic [3:0]          r_e  [LOG_FRAC+1];
    logic                r_one  [LOG_FRAC+1];
    logic                r_zero [LOG_FRAC+1];

    logic [3:0] w_e;
    assign w_e = lead_one(i_alpha[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v_lg[0] <= 1'b0;
        end else if (i_en) begin
            v_lg[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= POW_W'(i_alpha[15:0]) << (5'd30 - 5'(w_e));
            r_fr[0]   <= '0;
            r_e[0]    <= w_e;
            r_one[0]  <= (i_shin == '0) || i_alpha[16];
            r_zero[0] <= (i_alpha == '0);
        end
    end

    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
        logic [2*POW_W-1:0] w_sq;
        logic [31:0]        w_sh;

        assign w_sq = (2*POW_W)'(r_x[j]) * (2*POW_W)'(r_x[j]);
        assign w_sh = w_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                v_lg[j+1] <= 1'b0;
            end else if (i_en) begin
                v_lg[j+1] <= v_lg[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j+1]    <= w_sh[31] ? w_sh[31:1] : w_sh[30:0];
                r_fr[j+1]   <= {r_fr[j][LOG_FRAC-2:0], w_sh[31]};
                r_e[j+1]    <= r_e[j];
                r_one[j+1]  <= r_one[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // scale by the exponent
    logic              r_v1, r_v2;
    logic [PR_W-1:0]   r_prod;
    logic              r_one1, r_zero1, r_one2, r_zero2;
    logic [LG_W-1:0]   w_lg;
    logic [P_W-1:0]    w_p;

    assign w_lg = (LG_W'(5'd16 - {1'b0, r_e[LOG_FRAC]}) << LOG_FRAC)
                - LG_W'(r_fr[LOG_FRAC]);
    assign w_p  = r_prod[PR_W-1:6];

    logic [LOG_FRAC-1:0] r_f0;
    logic [4:0]          r_ip0;
    logic                r_big0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= v_lg[LOG_FRAC];
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PR_W'(w_lg) * PR_W'(i_shin);
            r_one1  <= r_one[LOG_FRAC];
            r_zero1 <= r_zero[LOG_FRAC];
            r_f0    <= w_p[LOG_FRAC-1:0];
            r_ip0   <= w_p[LOG_FRAC+4:LOG_FRAC];
            r_big0  <= (w_p[P_W-1:LOG_FRAC] >= IP_W'(31));
            r_one2  <= r_one1;
            r_zero2 <= r_zero1;
        end
    end

    // product of roots
    logic                v_rt  [LOG_FRAC+1];
    logic [POW_W-1:0]    r_r   [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] r_f   [LOG_FRAC+1];
    logic [4:0]          r_ip  [LOG_FRAC+1];
    logic                r_off [LOG_FRAC+1];
    logic                r_on  [LOG_FRAC+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v_rt[0] <= 1'b0;
        end else if (i_en) begin
            v_rt[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= ONE_Q30;
            r_f[0]   <= r_f0;
            r_ip[0]  <= r_ip0;
            r_off[0] <= r_zero2 || r_big0;
            r_on[0]  <= r_one2;
        end
    end

    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_root
        localparam logic [POW_W-1:0] ROOT = root_q30(j);
        logic [2*POW_W-1:0] w_m;

        assign w_m = (2*POW_W)'(r_r[j]) * (2*POW_W)'(ROOT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                v_rt[j+1] <= 1'b0;
            end else if (i_en) begin
                v_rt[j+1] <= v_rt[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[j+1]   <= r_f[j][LOG_FRAC-1-j] ? w_m[60:30] : r_r[j];
                r_f[j+1]   <= r_f[j];
                r_ip[j+1]  <= r_ip[j];
                r_off[j+1] <= r_off[j];
                r_on[j+1]  <= r_on[j];
            end
        end
    end

    logic             r_valid;
    logic [POW_W-1:0] r_pow;
    logic [POW_W-1:0] n_pow;

    always_comb begin
        priority if (r_on[LOG_FRAC]) begin
            n_pow = ONE_Q30;
        end else if (r_off[LOG_FRAC]) begin
            n_pow = '0;
        end else begin
            n_pow = r_r[LOG_FRAC] >> r_ip[LOG_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= v_rt[LOG_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pow <= n_pow;
        end
    end

    assign o_valid = r_valid;
    assign o_pow   = r_pow;

endmodule

[design/blinn_phong_brdf_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blinn_phong_brdf_eval
// Normalized Blinn-Phong BRDF, one RGB result per direction triple.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per clock while not stalled. The
// depth is set by the bit-per-stage square root (31 stages) and division
// (17 stages) of the half-vector cosine, and by the 20 squaring and 20
// root-multiply stages of the power unit. The whole pipeline holds while
// the output register is full and stalled; the input is stalled in exactly
// those cycles. Material registers may only be written while no
// transaction is in flight.
module blinn_phong_brdf_eval import bpb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int T_W  = 33;
    localparam int PH_W = 48;
    localparam int PL_W = 47;
    localparam int U_W  = 35;
    localparam int QH_W = 50;
    localparam int QL_W = 49;
    localparam int V_W  = 34;
    localparam logic [V_W-1:0] MAX_V = V_W'((64'd1 << OUT_W) - 64'd1);

    logic [CFG_W-1:0] r_diff [3];
    logic [CFG_W-1:0] r_spec [3];
    logic [CFG_W-1:0] r_shin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff <= '{default: '0};
            r_spec <= '{default: '0};
            r_shin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIFF_R: r_diff[0] <= i_cfg_data;
                REG_DIFF_G: r_diff[1] <= i_cfg_data;
                REG_DIFF_B: r_diff[2] <= i_cfg_data;
                REG_SPEC_R: r_spec[0] <= i_cfg_data;
                REG_SPEC_G: r_spec[1] <= i_cfg_data;
                REG_SPEC_B: r_spec[2] <= i_cfg_data;
                REG_SHIN:   r_shin    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_valid;

    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    logic               w_a_valid;
    logic [ALPHA_W-1:0] w_alpha;
    logic               w_p_valid;
    logic [POW_W-1:0]   w_pow;

    bpb_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_valid (w_a_valid),
        .o_alpha (w_alpha)
    );

    bpb_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_a_valid),
        .i_alpha (w_alpha),
        .i_shin  (r_shin),
        .o_valid (w_p_valid),
        .o_pow   (w_pow)
    );

    // colour channels
    logic              r_v1, r_v2, r_v3, r_v4;
    logic [POW_W-1:0]  r_pw;
    logic [T_W-1:0]    r_t   [3];
    logic [CFG_W-1:0]  r_dif1 [3];
    logic [CFG_W-1:0]  r_dif2 [3];
    logic [CFG_W-1:0]  r_dif3 [3];
    logic [CFG_W-1:0]  r_dif4 [3];
    logic [PH_W-1:0]   r_ph  [3];
    logic [PL_W-1:0]   r_pl  [3];
    logic [U_W-1:0]    r_u   [3];
    logic [QH_W-1:0]   r_qh  [3];
    logic [QL_W-1:0]   r_ql  [3];

    logic [47:0]       w_dp  [3];
    logic [64:0]       w_s3  [3];
    logic [67:0]       w_s5  [3];
    logic [V_W-1:0]    w_v   [3];
    logic [OUT_W-1:0]  w_val [3];
    logic [2:0]        w_clip;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_dp[c]  = 48'(r_diff[c]) * 48'(INV_PI_Q32);
            w_s3[c]  = (65'(r_ph[c]) << 16) + 65'(r_pl[c]);
            w_s5[c]  = (68'(r_qh[c]) << 17) + 68'(r_ql[c]);
            w_v[c]   = V_W'(r_dif4[c]) + V_W'(w_s5[c][67:39]);
            w_clip[c] = (w_v[c] > MAX_V);
            w_val[c] = w_clip[c] ? MAX_V[OUT_W-1:0] : w_v[c][OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= w_p_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pw <= w_pow;
            for (int c = 0; c < 3; c++) begin
                r_t[c]    <= T_W'(r_spec[c]) * (T_W'(r_shin) + T_W'(128));
                r_dif1[c] <= w_dp[c][47:32];
                r_ph[c]   <= PH_W'(r_t[c][32:16]) * PH_W'(r_pw);
                r_pl[c]   <= PL_W'(r_t[c][15:0]) * PL_W'(r_pw);
                r_dif2[c] <= r_dif1[c];
                r_u[c]    <= w_s3[c][64:30];
                r_dif3[c] <= r_dif2[c];
                r_qh[c]   <= QH_W'(r_u[c][34:17]) * QH_W'(INV_PI_Q32);
                r_ql[c]   <= QL_W'(r_u[c][16:0]) * QL_W'(INV_PI_Q32);
                r_dif4[c] <= r_dif3[c];
            end
            r_out_data.value_red   <= w_val[0];
            r_out_data.value_green <= w_val[1];
            r_out_data.value_blue  <= w_val[2];
            r_out_data.clipped     <= |w_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with a free output register");

    a_clip_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.clipped) |->
        (o_out_data.value_red == MAX_V[OUT_W-1:0] ||
         o_out_data.value_green == MAX_V[OUT_W-1:0] ||
         o_out_data.value_blue == MAX_V[OUT_W-1:0]))
        else $error("clip flag without a saturated channel");

    a_black_material: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_diff[0] == '0 && r_spec[0] == '0) |->
        (o_out_data.value_red == '0))
        else $error("red channel non-zero with zero reflectance");

endmodule
